// ===== hw/rtl/cv3_pkg.sv =====
`timescale 1ns / 1ps
// cv3_pkg: shared types and codes for the 3x3 multichannel convolution.
// Used by the controller, datapath and top level.
package cv3_pkg;

  // request codes on the input channel
  localparam logic [1:0] REQ_WEIGHT = 2'd0;
  localparam logic [1:0] REQ_BIAS   = 2'd1;
  localparam logic [1:0] REQ_PIXEL  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_HEIGHT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IN_CH  = 2'd2;
  localparam logic [1:0] REG_OUT_CH = 2'd3;

  localparam int CFG_DW = 11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIX,
    ST_RD,
    ST_MUL,
    ST_ACC,
    ST_SEND
  } cv3_state_t;

  // controller to datapath
  typedef struct packed {
    logic take;       // accept the input beat
    logic pix_start;  // pick next output pixel, first channel
    logic acc_en;     // add product into accumulator
    logic tap_step;   // advance ic/kh/kw
    logic load_out;   // load result register, move to next channel
  } cv3_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       run_start; // accepted beat completes a pixel with outputs due
    logic       tap_last;
    logic       oc_last;
    logic       more_pix;
    logic       out_free;
    logic [4:0] noc;
  } cv3_status_t;

endpackage

// ===== hw/rtl/cv3_if.sv =====
`timescale 1ns / 1ps
// cv3 input and result channel interfaces (valid/ready).
// Depends on nothing.
interface cv3_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [11:0] load_index;
  logic signed [15:0] value;
  modport source (output valid, req_type, load_index, value, input ready);
  modport sink (input valid, req_type, load_index, value, output ready);
endinterface

interface cv3_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] out_value;
  logic [9:0]  out_row;
  logic [7:0]  out_col;
  logic [3:0]  out_channel;
  logic        saturated;
  logic        last;
  modport source (output valid, out_value, out_row, out_col, out_channel, saturated, last,
                  input ready);
  modport sink (input valid, out_value, out_row, out_col, out_channel, saturated, last,
                output ready);
endinterface

// ===== hw/rtl/conv3x3_multichannel.sv =====
`timescale 1ns / 1ps
// conv3x3_multichannel: top level, 3x3 same-padded convolution over channels.
// Depends on cv3_pkg, cv3_if, cv3_ctrl and cv3_dp.
//
//   channel   dir   handshake     payload
//   in_bus    in    valid/ready   req_type, load_index, value
//   out_bus   out   valid/ready   out_value, out_row, out_col, out_channel, saturated, last
//   cfg_*     in    write enable  cfg_index, cfg_wdata
//
// Loads and non-final channel beats are taken straight from idle. A beat that
// completes a pixel with output pixels due starts a run for them (1..4):
// one shared MAC visits each window tap in three steps (memory read, multiply,
// accumulate), each pixel starts with a setup step and each output channel
// ends with a send step. Reset is synchronous, clears positions and loads
// register defaults; stores hold nothing useful until written. A stalled
// result holds the run in its send step.
module conv3x3_multichannel
  import cv3_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_IN_CH  = 16,
  parameter int MAX_OUT_CH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  cv3_in_if.sink            in_bus,
  cv3_out_if.source         out_bus,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  cv3_cmd_t    cmd;
  cv3_status_t sts;
  logic        in_ready;

  assign in_bus.ready = in_ready;

  cv3_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cv3_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_IN_CH  (MAX_IN_CH),
    .MAX_OUT_CH (MAX_OUT_CH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_req_type   (in_bus.req_type),
    .in_load_index (in_bus.load_index),
    .in_value      (in_bus.value),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_bus.valid),
    .out_ready     (out_bus.ready),
    .out_value     (out_bus.out_value),
    .out_row       (out_bus.out_row),
    .out_col       (out_bus.out_col),
    .out_channel   (out_bus.out_channel),
    .out_saturated (out_bus.saturated),
    .out_last      (out_bus.last)
  );

`ifndef SYNTHESIS
  // a run ends on the highest output channel in use
  a_last_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.last |-> out_bus.out_channel == 4'(sts.noc - 5'd1))
    else $error("last beat not on final output channel");

  // a clipped result sits at one of the rails
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.saturated |->
      (out_bus.out_value == 16'sh7fff || out_bus.out_value == 16'sh8000))
    else $error("saturated result off the rails");

  // no input beat is taken while a result is being loaded
  a_no_take_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !in_bus.ready)
    else $error("input accepted during a result run");
`endif

endmodule

// ===== hw/rtl/cv3_ctrl.sv =====
`timescale 1ns / 1ps
// cv3_ctrl: sequencer for loads, window taps and result delivery.
// Depends on cv3_pkg.
module cv3_ctrl
  import cv3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  cv3_status_t sts,
  output cv3_cmd_t    cmd
);

  cv3_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (sts.run_start) state_nxt = ST_PIX;
        end
      end
      ST_PIX: begin
        cmd.pix_start = 1'b1;
        state_nxt     = ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_en = 1'b1;
        if (sts.tap_last) begin
          state_nxt = ST_SEND;
        end else begin
          cmd.tap_step = 1'b1;
          state_nxt    = ST_RD;
        end
      end
      ST_SEND: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          if (!sts.oc_last) state_nxt = ST_RD;
          else if (sts.more_pix) state_nxt = ST_PIX;
          else state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/cv3_dp.sv =====
`timescale 1ns / 1ps
// cv3_dp: line store, weight store, biases, positions and the MAC.
// Depends on cv3_pkg.
module cv3_dp
  import cv3_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_IN_CH  = 16,
  parameter int MAX_OUT_CH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_DW-1:0]  cfg_wdata,
  input  logic [1:0]         in_req_type,
  input  logic [11:0]        in_load_index,
  input  logic signed [15:0] in_value,
  input  cv3_cmd_t           cmd,
  output cv3_status_t        sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_value,
  output logic [9:0]         out_row,
  output logic [7:0]         out_col,
  output logic [3:0]         out_channel,
  output logic               out_saturated,
  output logic               out_last
);

  localparam int LDEPTH = 3 * MAX_WIDTH * MAX_IN_CH;
  localparam int WDEPTH = MAX_OUT_CH * MAX_IN_CH * 9;
  localparam int LAW    = $clog2(LDEPTH);
  localparam int WAW    = $clog2(WDEPTH);
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int ICW    = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;
  localparam int OCW    = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
  localparam int ACCW   = 33 + $clog2(9 * MAX_IN_CH);
  localparam logic signed [ACCW-9:0] QMAX = (ACCW-8)'(32767);
  localparam logic signed [ACCW-9:0] QMIN = -(ACCW-8)'(32768);

  // configuration and positions
  logic [10:0] height_r;
  logic [8:0]  width_r;
  logic [4:0]  in_ch_r, out_ch_r;
  logic [9:0]  row_r;
  logic [CW-1:0]  col_r;
  logic [ICW-1:0] chan_r;
  logic [1:0]  rmod_r;
  logic [3:0]  mask_r;
  logic        out_valid_r;

  // run state
  logic [9:0]  er_r, h_r;
  logic [CW-1:0]  ec_r, w_r;
  logic [1:0]  ermod_r, hslot_r;
  logic [OCW-1:0] oc_r;
  logic [ICW-1:0] ic_r;
  logic [1:0]  kh_r, kw_r;
  logic signed [ACCW-1:0] acc_r;
  logic signed [15:0] lq_r, wq_r;
  logic        ok_r;
  logic signed [31:0] prod_r;

  logic signed [15:0] line_mem [LDEPTH];
  logic signed [15:0] wt_mem [WDEPTH];
  logic signed [15:0] bias_r [MAX_OUT_CH];

  logic signed [15:0] out_value_r;
  logic [9:0]  out_row_r;
  logic [7:0]  out_col_r;
  logic [3:0]  out_channel_r;
  logic        out_sat_r, out_last_r;

  // clamped configuration
  logic [10:0] hh, ww, w11;
  logic [6:0]  nic, n7;
  logic [4:0]  noc;

  always_comb begin
    hh  = (height_r < 11'd2) ? 11'd2 : ((height_r > 11'd1024) ? 11'd1024 : height_r);
    w11 = 11'(width_r);
    ww  = (w11 < 11'd2) ? 11'd2 : ((w11 > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : w11);
    n7  = 7'(in_ch_r);
    nic = (n7 < 7'd1) ? 7'd1 : ((n7 > 7'(MAX_IN_CH)) ? 7'(MAX_IN_CH) : n7);
    noc = (out_ch_r < 5'd1) ? 5'd1
        : ((out_ch_r > 5'(MAX_OUT_CH)) ? 5'(MAX_OUT_CH) : out_ch_r);
  end

  // pixel completion and the output pixels it makes due
  logic pix_in, chan_last, col_last, row_last;
  logic [3:0] mask_new;

  always_comb begin
    pix_in    = (in_req_type == REQ_PIXEL);
    chan_last = !(8'(chan_r) + 8'd1 < 8'(nic));
    col_last  = (11'(col_r) == ww - 11'd1);
    row_last  = (11'(row_r) == hh - 11'd1);
    mask_new  = {row_last & col_last, row_last & (col_r != '0),
                 (row_r != '0) & col_last, (row_r != '0) & (col_r != '0)};
  end

  // next output pixel from the due set, lowest first
  logic [1:0] k;
  logic [9:0] sel_h;
  logic [CW-1:0] sel_w;
  logic [1:0] sel_slot;

  always_comb begin
    if (mask_r[0]) k = 2'd0;
    else if (mask_r[1]) k = 2'd1;
    else if (mask_r[2]) k = 2'd2;
    else k = 2'd3;
    sel_h    = (k < 2'd2) ? er_r - 10'd1 : er_r;
    sel_w    = (k == 2'd0 || k == 2'd2) ? ec_r - CW'(1) : ec_r;
    sel_slot = (k < 2'd2) ? ((ermod_r == 2'd0) ? 2'd2 : ermod_r - 2'd1) : ermod_r;
  end

  // tap addresses and padding check
  logic [11:0] ihp, iwp;
  logic [2:0]  tsum;
  logic [1:0]  tslot;
  logic [CW-1:0] iw;
  logic        tap_ok;
  logic [LAW-1:0] raddr, waddr_l;
  logic [WAW-1:0] raddr_w;

  always_comb begin
    ihp    = 12'(h_r) + 12'(kh_r);
    iwp    = 12'(w_r) + 12'(kw_r);
    tap_ok = (ihp != 12'd0) && (ihp <= 12'(hh)) && (iwp != 12'd0) && (iwp <= 12'(ww));
    iw     = CW'(iwp - 12'd1);
    tsum   = 3'(hslot_r) + 3'(kh_r);
    case (tsum)
      3'd0:    tslot = 2'd2;
      3'd4:    tslot = 2'd0;
      default: tslot = 2'(tsum - 3'd1);
    endcase
    raddr   = LAW'((LAW'(tslot) * LAW'(MAX_WIDTH) + LAW'(iw)) * LAW'(MAX_IN_CH) + LAW'(ic_r));
    waddr_l = LAW'((LAW'(rmod_r) * LAW'(MAX_WIDTH) + LAW'(col_r)) * LAW'(MAX_IN_CH)
                   + LAW'(chan_r));
    raddr_w = WAW'((WAW'(oc_r) * WAW'(MAX_IN_CH) + WAW'(ic_r)) * WAW'(9)
                   + WAW'(kh_r) * WAW'(3) + WAW'(kw_r));
  end

  // memories: write on accepted beat, registered read each cycle
  always_ff @(posedge clk) begin
    if (cmd.take && pix_in) line_mem[waddr_l] <= in_value;
    if (cmd.take && in_req_type == REQ_WEIGHT && 32'(in_load_index) < WDEPTH)
      wt_mem[WAW'(in_load_index)] <= in_value;
    if (cmd.take && in_req_type == REQ_BIAS && 32'(in_load_index) < MAX_OUT_CH)
      bias_r[OCW'(in_load_index)] <= in_value;
    lq_r <= line_mem[raddr];
    wq_r <= wt_mem[raddr_w];
    ok_r <= tap_ok;
  end

  // results after rounding toward minus infinity
  logic signed [ACCW-9:0] q;
  logic sat_hi, sat_lo;

  always_comb begin
    q      = (ACCW-8)'(acc_r >>> 8);
    sat_hi = (q > QMAX);
    sat_lo = (q < QMIN);
  end

  logic tap_last, oc_last;
  assign tap_last = (kw_r == 2'd2) && (kh_r == 2'd2) && (7'(ic_r) == nic - 7'd1);
  assign oc_last  = (5'(oc_r) == noc - 5'd1);

  // MAC, counters and result payload
  always_ff @(posedge clk) begin
    prod_r <= ok_r ? lq_r * wq_r : 32'sd0;
    if (cmd.take) begin
      er_r    <= row_r;
      ec_r    <= col_r;
      ermod_r <= rmod_r;
    end
    if (cmd.pix_start) begin
      h_r     <= sel_h;
      w_r     <= sel_w;
      hslot_r <= sel_slot;
      oc_r    <= '0;
      ic_r    <= '0;
      kh_r    <= '0;
      kw_r    <= '0;
      acc_r   <= ACCW'(bias_r[0]) <<< 8;
    end
    if (cmd.acc_en) acc_r <= acc_r + ACCW'(prod_r);
    if (cmd.tap_step) begin
      if (kw_r != 2'd2) begin
        kw_r <= kw_r + 2'd1;
      end else begin
        kw_r <= '0;
        if (kh_r != 2'd2) begin
          kh_r <= kh_r + 2'd1;
        end else begin
          kh_r <= '0;
          ic_r <= ic_r + ICW'(1);
        end
      end
    end
    if (cmd.load_out) begin
      out_value_r   <= sat_hi ? 16'sh7fff : (sat_lo ? 16'sh8000 : 16'(q));
      out_sat_r     <= sat_hi | sat_lo;
      out_row_r     <= h_r;
      out_col_r     <= 8'(w_r);
      out_channel_r <= 4'(oc_r);
      out_last_r    <= oc_last && (mask_r == 4'd0);
      if (!oc_last) begin
        oc_r  <= oc_r + OCW'(1);
        ic_r  <= '0;
        kh_r  <= '0;
        kw_r  <= '0;
        acc_r <= ACCW'(bias_r[oc_r + OCW'(1)]) <<< 8;
      end
    end
  end

  // configuration, positions, due set and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r    <= 11'd1024;
      width_r     <= 9'd256;
      in_ch_r     <= 5'd1;
      out_ch_r    <= 5'd16;
      row_r       <= '0;
      col_r       <= '0;
      chan_r      <= '0;
      rmod_r      <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cmd.load_out) out_valid_r <= 1'b1;
      if (cmd.pix_start) mask_r[k] <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_HEIGHT: height_r <= cfg_wdata;
          REG_WIDTH:  width_r  <= 9'(cfg_wdata);
          REG_IN_CH:  in_ch_r  <= 5'(cfg_wdata);
          REG_OUT_CH: out_ch_r <= 5'(cfg_wdata);
          default:    height_r <= height_r;
        endcase
        row_r  <= '0;
        col_r  <= '0;
        chan_r <= '0;
        rmod_r <= '0;
      end else if (cmd.take && pix_in) begin
        if (!chan_last) begin
          chan_r <= chan_r + ICW'(1);
        end else begin
          chan_r <= '0;
          mask_r <= mask_new;
          if (!col_last) begin
            col_r <= col_r + CW'(1);
          end else begin
            col_r <= '0;
            if (row_last) begin
              row_r  <= '0;
              rmod_r <= '0;
            end else begin
              row_r  <= row_r + 10'd1;
              rmod_r <= (rmod_r == 2'd2) ? 2'd0 : rmod_r + 2'd1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    sts.run_start = pix_in && chan_last && (mask_new != 4'd0);
    sts.tap_last  = tap_last;
    sts.oc_last   = oc_last;
    sts.more_pix  = (mask_r != 4'd0);
    sts.out_free  = !out_valid_r || out_ready;
    sts.noc       = noc;
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_channel   = out_channel_r;
  assign out_saturated = out_sat_r;
  assign out_last      = out_last_r;

endmodule

// ===== test/tb_conv3x3_multichannel.sv =====
`timescale 1ns / 1ps
// tb_conv3x3_multichannel: self-checking bench for the 3x3 multichannel convolution.
// Depends on cv3_pkg, cv3_in_if, cv3_out_if and the conv3x3_multichannel RTL.
module tb_conv3x3_multichannel;
  import cv3_pkg::*;

  localparam int MAXW = 256;
  localparam int MAXIC = 16;
  localparam int MAXOC = 16;
  localparam int NWEIGHT = MAXOC * MAXIC * 9;
  localparam int LIMIT = 4000000;
  localparam int DRAIN = 200;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic signed [15:0] value;
    logic [9:0] row;
    logic [7:0] col;
    logic [3:0] channel;
    logic sat;
    logic last;
  } conv_result_t;

  // directed row: typed expectation only on the first result of a run
  typedef struct {
    logic [1:0] req;
    logic [11:0] idx;
    logic [15:0] val;
    bit chk;
    logic signed [15:0] ev;
    bit es;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_HEIGHT;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  cv3_in_if in_bus ();
  cv3_out_if out_bus ();

  conv3x3_multichannel dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // shadow state of the block
  logic signed [15:0] line_mem [0:3*MAXW*MAXIC-1];
  logic signed [15:0] kernel_mem [0:NWEIGHT-1];
  logic signed [15:0] bias_mem [0:MAXOC-1];
  int unsigned reg_h, reg_w, reg_nic, reg_noc;
  int unsigned pos_row, pos_col, pos_ch;

  conv_result_t conv_q[$];
  int errors = 0;
  int cycles = 0;
  int results_seen = 0;
  int pixel_beats = 0;
  int load_beats = 0;
  int phases = 0;

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // window sum for one output pixel, all output channels
  function automatic void conv_pixel(int unsigned h, int unsigned w, int unsigned hh,
                                     int unsigned ww, int unsigned nic, int unsigned noc);
    conv_result_t res;
    longint acc, q;
    int ih, iw;
    for (int oc = 0; oc < noc; oc++) begin
      acc = longint'(bias_mem[oc]) * 256;
      for (int ic = 0; ic < nic; ic++)
        for (int kh = 0; kh < 3; kh++)
          for (int kw = 0; kw < 3; kw++) begin
            ih = h + kh - 1;
            iw = w + kw - 1;
            if (ih >= 0 && ih < hh && iw >= 0 && iw < ww)
              acc += longint'(line_mem[((ih % 3) * MAXW + iw) * MAXIC + ic]) *
                     longint'(kernel_mem[(oc * MAXIC + ic) * 9 + kh * 3 + kw]);
          end
      q = acc >>> 8;
      res.sat = 1'b0;
      if (q > 32767) begin q = 32767; res.sat = 1'b1; end
      if (q < -32768) begin q = -32768; res.sat = 1'b1; end
      res.value = q[15:0];
      res.row = h[9:0];
      res.col = w[7:0];
      res.channel = oc[3:0];
      res.last = 1'b0;
      conv_q.push_back(res);
    end
  endfunction

  // apply one accepted beat; returns the number of results it causes
  function automatic int conv_step(logic [1:0] req, logic [11:0] idx, logic [15:0] val);
    int unsigned hh, ww, nic, noc, r, c;
    int n0;
    n0 = conv_q.size();
    if (req == REQ_WEIGHT) begin
      if (idx < NWEIGHT) kernel_mem[idx] = val;
      return 0;
    end
    if (req == REQ_BIAS) begin
      if (idx < MAXOC) bias_mem[idx] = val;
      return 0;
    end
    if (req != REQ_PIXEL) return 0;
    hh = clampu(reg_h, 2, 1024);
    ww = clampu(reg_w, 2, MAXW);
    nic = clampu(reg_nic, 1, MAXIC);
    noc = clampu(reg_noc, 1, MAXOC);
    r = pos_row;
    c = pos_col;
    line_mem[((r % 3) * MAXW + c) * MAXIC + pos_ch] = val;
    if (pos_ch + 1 < nic) begin
      pos_ch++;
      return 0;
    end
    if (r >= 1 && c >= 1) conv_pixel(r - 1, c - 1, hh, ww, nic, noc);
    if (r >= 1 && c == ww - 1) conv_pixel(r - 1, c, hh, ww, nic, noc);
    if (r == hh - 1) begin
      if (c >= 1) conv_pixel(r, c - 1, hh, ww, nic, noc);
      if (c == ww - 1) conv_pixel(r, c, hh, ww, nic, noc);
    end
    if (conv_q.size() > n0) conv_q[$].last = 1'b1;
    pos_ch = 0;
    c++;
    if (c >= ww) begin
      c = 0;
      r++;
      if (r >= hh) r = 0;
    end
    pos_col = c;
    pos_row = r;
    return conv_q.size() - n0;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  bit sender_busy = 1'b0;

  // drive one beat, hold it until accepted, update the shadow model
  task automatic send_beat(input logic [1:0] req, input logic [11:0] idx,
                           input logic [15:0] val, input int gap, output int nres);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.req_type <= req;
    in_bus.load_index <= idx;
    in_bus.value <= val;
    do @(posedge clk); while (!in_bus.ready);
    nres = conv_step(req, idx, val);
    if (req == REQ_PIXEL) pixel_beats++;
    else load_beats++;
  endtask

  // load weights and biases of output and input channels 0 and 1
  task automatic load_kernels();
    int nres;
    for (int oc = 0; oc < 2; oc++)
      for (int ic = 0; ic < 2; ic++)
        for (int k = 0; k < 9; k++)
          send_beat(REQ_WEIGHT, 12'((oc * MAXIC + ic) * 9 + k),
                    16'($urandom_range(0, 65535)), 0, nres);
    for (int oc = 0; oc < 2; oc++)
      send_beat(REQ_BIAS, 12'(oc), 16'($urandom_range(0, 65535)), 0, nres);
  endtask

  // drop valid and wait until every expected result has come
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (conv_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] ri, input logic [CFG_DW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= ri;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (ri)
      REG_HEIGHT: reg_h = data;
      REG_WIDTH:  reg_w = data[8:0];
      REG_IN_CH:  reg_nic = data[4:0];
      default:    reg_noc = data[4:0];
    endcase
    pos_row = 0;
    pos_col = 0;
    pos_ch = 0;
  endtask

  task automatic set_frame(input int h, input int w, input int nic, input int noc);
    drain_results();
    write_reg(REG_HEIGHT, h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_IN_CH, nic);
    write_reg(REG_OUT_CH, noc);
    phases++;
  endtask

  function automatic logic [15:0] rand_sample();
    int p;
    p = $urandom_range(0, 19);
    if (p == 0) return 16'h7fff;
    if (p == 1) return 16'h8000;
    if (p < 6) return $urandom_range(0, 65535);
    return 16'($signed($urandom_range(0, 1023)) - 512);
  endfunction

  // result side: check accepted beats, then pick the next ready
  int stall_left = 0;
  bit steady = 1'b0;
  always @(posedge clk) begin
    conv_result_t exp_r;
    cycles <= cycles + 1;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        results_seen++;
        if (conv_q.size() == 0) begin
          $error("result beat with nothing expected: row %0d col %0d ch %0d",
                 out_bus.out_row, out_bus.out_col, out_bus.out_channel);
          errors++;
        end else begin
          exp_r = conv_q.pop_front();
          if (out_bus.out_value !== exp_r.value) begin
            $error("out_value: expected %0d, got %0d", exp_r.value, out_bus.out_value);
            errors++;
          end
          if (out_bus.out_row !== exp_r.row) begin
            $error("out_row: expected %0d, got %0d", exp_r.row, out_bus.out_row);
            errors++;
          end
          if (out_bus.out_col !== exp_r.col) begin
            $error("out_col: expected %0d, got %0d", exp_r.col, out_bus.out_col);
            errors++;
          end
          if (out_bus.out_channel !== exp_r.channel) begin
            $error("out_channel: expected %0d, got %0d", exp_r.channel, out_bus.out_channel);
            errors++;
          end
          if (out_bus.saturated !== exp_r.sat) begin
            $error("saturated: expected %0d, got %0d", exp_r.sat, out_bus.saturated);
            errors++;
          end
          if (out_bus.last !== exp_r.last) begin
            $error("last: expected %0d, got %0d", exp_r.last, out_bus.last);
            errors++;
          end
        end
      end
      // switch between steady stretches and random stalls
      if ($urandom_range(0, 199) == 0) steady = ~steady;
      if (steady) begin
        out_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  dir_row_t dir_tab[$];

  initial begin
    int nres, want, p, idx, target, nbeats;
    bit calm;
    in_bus.valid = 1'b0;
    in_bus.req_type = REQ_WEIGHT;
    in_bus.load_index = '0;
    in_bus.value = '0;
    reg_h = 1024; reg_w = 256; reg_nic = 1; reg_noc = 16;
    pos_row = 0; pos_col = 0; pos_ch = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset frame: first row pixels emit nothing
    for (int i = 0; i < 3; i++) send_beat(REQ_PIXEL, 12'(i), rand_sample(), pick_gap(), nres);

    // load the channels that every frame below reads
    load_kernels();

    // directed: ignored requests, extreme loads, saturating 2x2 frames
    set_frame(2, 2, 1, 2);
    dir_tab.push_back('{REQ_UNUSED, 12'hfff, 16'hffff, 0, 0, 0});
    dir_tab.push_back('{REQ_WEIGHT, 12'd2304, 16'h1234, 0, 0, 0});
    dir_tab.push_back('{REQ_WEIGHT, 12'hfff, 16'h5555, 0, 0, 0});
    dir_tab.push_back('{REQ_BIAS, 12'd16, 16'haaaa, 0, 0, 0});
    dir_tab.push_back('{REQ_BIAS, 12'd0, 16'h7fff, 0, 0, 0});
    dir_tab.push_back('{REQ_BIAS, 12'd1, 16'h8000, 0, 0, 0});
    for (int k = 0; k < 9; k++) dir_tab.push_back('{REQ_WEIGHT, 12'(k), 16'h7fff, 0, 0, 0});
    for (int k = 0; k < 3; k++) dir_tab.push_back('{REQ_PIXEL, 12'd0, 16'h7fff, 0, 0, 0});
    dir_tab.push_back('{REQ_PIXEL, 12'd0, 16'h7fff, 1, 16'sh7fff, 1});
    for (int k = 0; k < 3; k++) dir_tab.push_back('{REQ_PIXEL, 12'd0, 16'h8000, 0, 0, 0});
    dir_tab.push_back('{REQ_PIXEL, 12'd0, 16'h8000, 1, -16'sh8000, 1});
    foreach (dir_tab[i]) begin
      send_beat(dir_tab[i].req, dir_tab[i].idx, dir_tab[i].val, pick_gap(), nres);
      want = conv_q.size() - nres;
      if (dir_tab[i].chk && (nres == 0 || conv_q[want].value !== dir_tab[i].ev ||
                             conv_q[want].sat !== dir_tab[i].es)) begin
        $error("directed row %0d: expected first result %0d sat %0d", i,
               dir_tab[i].ev, dir_tab[i].es);
        errors++;
      end
    end

    // replace the extreme kernel and biases with ordinary values
    for (int k = 0; k < 9; k++)
      send_beat(REQ_WEIGHT, 12'(k), rand_sample(), pick_gap(), nres);
    for (int k = 0; k < 2; k++)
      send_beat(REQ_BIAS, 12'(k), rand_sample(), pick_gap(), nres);

    // extremes: largest frame, then out-of-range values that clamp
    set_frame(1024, 256, 16, 16);
    for (int i = 0; i < 12; i++) send_beat(REQ_PIXEL, 0, rand_sample(), pick_gap(), nres);
    set_frame(0, 0, 0, 0);
    for (int i = 0; i < 8; i++) send_beat(REQ_PIXEL, 0, rand_sample(), pick_gap(), nres);
    set_frame(2047, 511, 31, 31);
    for (int i = 0; i < 12; i++) send_beat(REQ_PIXEL, 0, rand_sample(), pick_gap(), nres);

    // random small frames, with loads and unused requests mixed in
    target = pixel_beats + 56;
    while (pixel_beats < target) begin
      set_frame($urandom_range(2, 6), $urandom_range(2, 8), $urandom_range(1, 2),
                $urandom_range(1, 2));
      calm = ($urandom_range(0, 3) == 0);
      nbeats = $urandom_range(10, 25);
      for (int i = 0; i < nbeats; i++) begin
        p = $urandom_range(0, 99);
        if (i == 10 && phases % 2 == 0) drain_results();
        if (p < 80) begin
          send_beat(REQ_PIXEL, 12'($urandom_range(0, 4095)), rand_sample(),
                    calm ? 0 : pick_gap(), nres);
        end else if (p < 88) begin
          idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                            : $urandom_range(0, NWEIGHT - 1);
          send_beat(REQ_WEIGHT, 12'(idx), rand_sample(), calm ? 0 : pick_gap(), nres);
        end else if (p < 94) begin
          send_beat(REQ_BIAS, 12'($urandom_range(0, 31)), rand_sample(),
                    calm ? 0 : pick_gap(), nres);
        end else begin
          send_beat(REQ_UNUSED, 12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)),
                    calm ? 0 : pick_gap(), nres);
        end
      end
    end

    // wait out remaining results, then a quiet tail
    drain_results();
    repeat (DRAIN) @(posedge clk);

    $display("Covered %0d pixel beats and %0d load or unused beats over %0d frame settings,",
             pixel_beats, load_beats, phases);
    $display("checking %0d result beats, %0d mismatches.", results_seen, errors);
    if (errors == 0 && conv_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
